### rtl/core/paged_memory_with_permissions_defines.svh
// Assertion macros for the paged memory block.
`ifndef PAGED_MEMORY_WITH_PERMISSIONS_DEFINES_SVH
`define PAGED_MEMORY_WITH_PERMISSIONS_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define PMP_ASSERT_IMPL(label, clk, rstn, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |-> (rhs)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define PMP_ASSERT_NEXT(label, clk, rstn, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |=> (rhs)) \
        else $error(msg);
`endif

### rtl/core/pmp_pkg.sv
// Shared types and codes for the paged memory block.
package pmp_pkg;
    localparam logic [2:0] OP_READ    = 3'd0;
    localparam logic [2:0] OP_EXEC    = 3'd1;
    localparam logic [2:0] OP_WRITE   = 3'd2;
    localparam logic [2:0] OP_INIT    = 3'd3;
    localparam logic [2:0] OP_MAP     = 3'd4;
    localparam logic [2:0] OP_UNMAP   = 3'd5;
    localparam logic [2:0] OP_PROTECT = 3'd6;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_DENIED  = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] address;
        logic [3:0]  access_bytes;
        logic [63:0] write_data;
        logic [3:0]  perm_bits;
        logic [23:0] range_bytes;
    } pmp_item_t;

    typedef struct packed {
        logic [63:0] read_data;
        logic [1:0]  status;
    } pmp_result_t;

    function automatic logic [3:0] need_bit(input logic [2:0] op);
        logic [3:0] b;
        unique case (op[1:0])
            2'd0: b = 4'b0001;
            2'd1: b = 4'b0100;
            2'd2: b = 4'b0010;
            default: b = 4'b1000;
        endcase
        return b;
    endfunction
endpackage

### rtl/core/pmp_ram.sv
// Generic single-port RAM with registered read.
module pmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

### rtl/core/pmp_front.sv
// Front end: accepts items, classifies them and queues them for the back end.
module pmp_front
    import pmp_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  pmp_item_t in_item,
    output logic      q_valid,
    input  logic      q_ready,
    output pmp_item_t q_item
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    pmp_item_t      buf_reg [DEPTH];
    logic [PW-1:0]  wp_reg, rp_reg;
    logic [PW:0]    cnt_reg;
    pmp_item_t      cls;
    logic           push, pop;

    // Normalize: the unused op code 7 becomes a harmless protect of zero bytes.
    always_comb begin
        cls = in_item;
        if (in_item.op == 3'd7) begin
            cls.op = OP_PROTECT;
            cls.range_bytes = '0;
        end
    end

    assign in_ready = (cnt_reg != (PW+1)'(DEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = buf_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wp_reg] <= cls;
        end
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= (wp_reg == PW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (pop)  rp_reg <= (rp_reg == PW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end
endmodule

### rtl/core/pmp_back.sv
// Back end: slot table lookup, page walks, page zeroing and byte accesses.
module pmp_back
    import pmp_pkg::*;
#(
    parameter int PAGE_BYTES = 4096,
    parameter int PAGE_SLOTS = 16,
    parameter int MAX_ACCESS_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        safe_mode,
    input  logic        q_valid,
    output logic        q_ready,
    input  pmp_item_t   q_item,
    output logic        out_valid,
    input  logic        out_ready,
    output pmp_result_t out_res
);
    localparam int OB = $clog2(PAGE_BYTES);
    localparam int SB = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
    localparam int PB = 32 - OB;
    localparam int AB = SB + OB;
    localparam int MAXN = (MAX_ACCESS_BYTES < 8) ? MAX_ACCESS_BYTES : 8;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_BYTE  = 4'd2;
    localparam logic [3:0] S_RWAIT = 4'd3;
    localparam logic [3:0] S_WALK  = 4'd4;
    localparam logic [3:0] S_ZERO  = 4'd5;
    localparam logic [3:0] S_DONE  = 4'd6;
    localparam logic [3:0] S_FAST  = 4'd7;

    logic [3:0]           state_reg;
    pmp_item_t            it_reg;
    logic [PAGE_SLOTS-1:0] valid_reg;
    logic [PB-1:0]        tag_reg  [PAGE_SLOTS];
    logic [3:0]           perm_reg [PAGE_SLOTS];

    logic [PB-1:0]  pn_reg;
    logic [PB-1:0]  cnt_reg;
    logic [3:0]     n_reg, i_reg;
    logic [31:0]    ba_reg;
    logic [SB-1:0]  slot_reg;
    logic [OB-1:0]  zi_reg;
    logic [63:0]    acc_reg;
    logic [1:0]     st_reg;
    logic           ov_reg;

    // Associative lookup of one page number.
    function automatic logic [SB:0] lookup(input logic [PB-1:0] pn,
            input logic [PAGE_SLOTS-1:0] v, input logic [PB-1:0] t [PAGE_SLOTS]);
        logic [SB:0] r;
        r = {1'b0, {SB{1'b0}}};
        for (int k = PAGE_SLOTS-1; k >= 0; k--) begin
            if (v[k] && t[k] == pn) r = {1'b1, SB'(k)};
        end
        return r;
    endfunction

    logic [SB:0] free_s;
    logic [SB:0] free_cnt;
    always_comb begin
        free_s = '0;
        free_cnt = '0;
        for (int k = PAGE_SLOTS-1; k >= 0; k--) begin
            if (!valid_reg[k]) free_s = {1'b1, SB'(k)};
        end
        for (int k = 0; k < PAGE_SLOTS; k++) begin
            free_cnt = free_cnt + (SB+1)'(!valid_reg[k]);
        end
    end

    // Pages of the access held in it_reg.
    logic [3:0]    nsat;
    logic [PB-1:0] pn0, pn1;
    logic          two;
    logic [OB:0]   room;
    logic [SB:0]   l0, l1, lw;
    logic [3:0]    nb;
    always_comb begin
        nsat = (it_reg.access_bytes > 4'(MAXN)) ? 4'(MAXN) : it_reg.access_bytes;
        pn0  = it_reg.address[31:OB];
        pn1  = pn0 + 1'b1;
        room = (OB+1)'(PAGE_BYTES) - {1'b0, it_reg.address[OB-1:0]};
        two  = ({{(OB-3){1'b0}}, nsat} > room);
        l0   = lookup(pn0, valid_reg, tag_reg);
        l1   = lookup(pn1, valid_reg, tag_reg);
        lw   = lookup(pn_reg, valid_reg, tag_reg);
        nb   = need_bit(it_reg.op);
    end

    logic          is_store;
    assign is_store = it_reg.op[1];

    // Byte RAM port.
    logic          ram_we;
    logic [AB-1:0] ram_addr;
    logic [7:0]    ram_wd, ram_rd;
    logic [SB:0]   lb;
    logic [PB-1:0] bpn;
    assign bpn = ba_reg[31:OB];
    assign lb  = lookup(bpn, valid_reg, tag_reg);

    always_comb begin
        ram_we = 1'b0;
        ram_addr = {lb[SB-1:0], ba_reg[OB-1:0]};
        ram_wd = it_reg.write_data[8*i_reg[2:0] +: 8];
        if (state_reg == S_ZERO) begin
            ram_we = 1'b1;
            ram_addr = {slot_reg, zi_reg};
            ram_wd = '0;
        end else if (state_reg == S_BYTE && is_store && lb[SB]) begin
            ram_we = 1'b1;
        end
    end

    pmp_ram #(.WIDTH(8), .DEPTH(PAGE_SLOTS*PAGE_BYTES)) u_ram (
        .aclk(aclk), .we(ram_we), .addr(ram_addr), .wdata(ram_wd), .rdata(ram_rd));

    assign q_ready   = (state_reg == S_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
    assign out_res   = '{read_data: acc_reg, status: st_reg};

    logic [31:0] last_a;
    assign last_a = it_reg.address + {8'd0, it_reg.range_bytes} - 32'd1;

    logic        zero_ret;
    always_ff @(posedge aclk) begin
        if (q_valid && q_ready) it_reg <= q_item;
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            ov_reg <= 1'b0;
            zero_ret <= 1'b0;
        end else begin
            if (ov_reg && out_ready) ov_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid && q_ready) state_reg <= S_FAST;
                end
                S_FAST: begin
                    acc_reg <= '0;
                    st_reg <= ST_OK;
                    i_reg <= '0;
                    ba_reg <= it_reg.address;
                    if (it_reg.op[2]) begin
                        pn_reg <= it_reg.address[31:OB];
                        cnt_reg <= last_a[31:OB] - it_reg.address[31:OB];
                        state_reg <= (it_reg.range_bytes == '0) ? S_DONE : S_WALK;
                    end else begin
                        n_reg <= nsat;
                        state_reg <= (nsat == '0) ? S_DONE : S_CHECK;
                    end
                end
                S_CHECK: begin
                    state_reg <= S_BYTE;
                    if (safe_mode) begin
                        if (!l0[SB]) begin
                            st_reg <= ST_MISSING; state_reg <= S_DONE;
                        end else if ((perm_reg[l0[SB-1:0]] & nb) != nb) begin
                            st_reg <= ST_DENIED; state_reg <= S_DONE;
                        end else if (two && !l1[SB]) begin
                            st_reg <= ST_MISSING; state_reg <= S_DONE;
                        end else if (two && (perm_reg[l1[SB-1:0]] & nb) != nb) begin
                            st_reg <= ST_DENIED; state_reg <= S_DONE;
                        end
                    end else if (is_store) begin
                        // Create missing pages one at a time; each comes back here.
                        if ((SB+1)'(!l0[SB]) + (SB+1)'(two && !l1[SB]) > free_cnt) begin
                            st_reg <= ST_FULL; state_reg <= S_DONE;
                        end else if (!l0[SB] || (two && !l1[SB])) begin
                            slot_reg <= free_s[SB-1:0];
                            valid_reg[free_s[SB-1:0]] <= 1'b1;
                            tag_reg[free_s[SB-1:0]] <= !l0[SB] ? pn0 : pn1;
                            perm_reg[free_s[SB-1:0]] <= 4'hF;
                            zi_reg <= '0;
                            zero_ret <= 1'b0;
                            state_reg <= S_ZERO;
                        end
                    end
                end
                S_ZERO: begin
                    zi_reg <= zi_reg + 1'b1;
                    if (zi_reg == OB'(PAGE_BYTES-1)) begin
                        if (zero_ret) begin
                            cnt_reg <= cnt_reg - 1'b1;
                            pn_reg <= pn_reg + 1'b1;
                            state_reg <= (cnt_reg == '0) ? S_DONE : S_WALK;
                        end else begin
                            state_reg <= S_CHECK;
                        end
                    end
                end
                S_BYTE: begin
                    if (is_store || !lb[SB]) begin
                        i_reg <= i_reg + 1'b1;
                        ba_reg <= ba_reg + 32'd1;
                        if (i_reg + 1'b1 == n_reg) state_reg <= S_DONE;
                    end else begin
                        state_reg <= S_RWAIT;
                    end
                end
                S_RWAIT: begin
                    acc_reg[8*i_reg[2:0] +: 8] <= ram_rd;
                    i_reg <= i_reg + 1'b1;
                    ba_reg <= ba_reg + 32'd1;
                    state_reg <= (i_reg + 1'b1 == n_reg) ? S_DONE : S_BYTE;
                end
                S_WALK: begin
                    if (it_reg.op == OP_MAP && !lw[SB]) begin
                        if (!free_s[SB]) begin
                            st_reg <= ST_FULL; state_reg <= S_DONE;
                        end else begin
                            slot_reg <= free_s[SB-1:0];
                            valid_reg[free_s[SB-1:0]] <= 1'b1;
                            tag_reg[free_s[SB-1:0]] <= pn_reg;
                            perm_reg[free_s[SB-1:0]] <= it_reg.perm_bits;
                            zi_reg <= '0;
                            zero_ret <= 1'b1;
                            state_reg <= S_ZERO;
                        end
                    end else begin
                        if (lw[SB]) begin
                            if (it_reg.op == OP_MAP)
                                perm_reg[lw[SB-1:0]] <= perm_reg[lw[SB-1:0]] | it_reg.perm_bits;
                            else if (it_reg.op == OP_UNMAP)
                                valid_reg[lw[SB-1:0]] <= 1'b0;
                            else
                                perm_reg[lw[SB-1:0]] <= it_reg.perm_bits;
                        end
                        cnt_reg <= cnt_reg - 1'b1;
                        pn_reg <= pn_reg + 1'b1;
                        if (cnt_reg == '0) state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    // The output register is always empty here: an item starts only then.
                    if (!ov_reg) begin
                        if (st_reg != ST_OK || is_store || it_reg.op[2]) acc_reg <= '0;
                        ov_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

### rtl/core/paged_memory_with_permissions.sv
// Top level: sparse page-mapped memory with per-page permissions.
// A byte read from a present page passes S_BYTE and S_RWAIT, any other byte S_BYTE alone;
//   map, unmap and protect walk the range page by page; a created page is zeroed byte by byte.
//   The back end handles one item at a time and takes the next queued item only after the
//   result transfer, while the 2-entry queue keeps taking input.
// Reset (aresetn low, synchronous) clears all slot valid flags, the queue and sets safe_mode.
module paged_memory_with_permissions
    import pmp_pkg::*;
#(
    parameter int PAGE_BYTES = 4096,
    parameter int PAGE_SLOTS = 16,
    parameter int MAX_ACCESS_BYTES = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic         cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // op[2:0], address[34:3], access_bytes[38:35], write_data[102:39],
    // perm_bits[106:103], range_bytes[130:107], zero fill to 136
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // read_data[63:0], status[65:64], zero fill to 72
    output logic [71:0]  m_tdata
);
    // The page byte RAM needs no clearing pass: a page is zeroed when its slot is created.
    logic        safe_reg;
    pmp_item_t   in_item, q_item;
    logic        q_valid, q_ready;
    pmp_result_t res;

    always_ff @(posedge aclk) begin
        if (!aresetn) safe_reg <= 1'b1;
        else if (cfg_we) safe_reg <= cfg_wdata;
    end

    assign in_item = '{op: s_tdata[2:0], address: s_tdata[34:3],
                       access_bytes: s_tdata[38:35], write_data: s_tdata[102:39],
                       perm_bits: s_tdata[106:103], range_bytes: s_tdata[130:107]};

    pmp_front #(.DEPTH(2)) u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item));

    pmp_back #(.PAGE_BYTES(PAGE_BYTES), .PAGE_SLOTS(PAGE_SLOTS),
               .MAX_ACCESS_BYTES(MAX_ACCESS_BYTES)) u_back (
        .aclk(aclk), .aresetn(aresetn), .safe_mode(safe_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res));

    assign m_tdata = {6'd0, res.status, res.read_data};
endmodule

### rtl/core/pmp_checker.sv
// Port-level checker for the paged memory block, bound to the top level.
`include "paged_memory_with_permissions_defines.svh"
module pmp_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [71:0]  m_tdata
);
    `PMP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `PMP_ASSERT_IMPL(a_fault_zero, aclk, aresetn, m_tvalid && m_tdata[65:64] != 2'd0, m_tdata[63:0] == 64'd0, "fault with read data")
    `PMP_ASSERT_IMPL(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[71:66] == 6'd0, "padding not zero")
endmodule

bind paged_memory_with_permissions pmp_checker u_pmp_checker (
    .aclk(aclk), .aresetn(aresetn),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata));

### test/tb_paged_memory_with_permissions.sv
// Self-checking testbench for paged_memory_with_permissions: random and directed stream traffic.
module tb_paged_memory_with_permissions;
    timeunit 1ns;
    timeprecision 1ps;
    import pmp_pkg::*;

    localparam int PG   = 4096;
    localparam int NSLT = 16;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_we = 1'b0;
    logic         cfg_wdata = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // op, address, access_bytes, write_data, perm_bits, range_bytes (lowest first)
    logic [135:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // read_data, status (lowest first)
    logic [71:0]  m_tdata;

    paged_memory_with_permissions u_dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Shadow page table, mirrored transfer by transfer on the input side.
    logic [19:0] pg_tag [NSLT];
    logic        pg_live [NSLT];
    logic [3:0]  pg_perm [NSLT];
    logic [7:0]  pg_mem [NSLT*PG];
    logic        safe_q;

    pmp_result_t exp_results [$];
    int          errors = 0;
    int          stall_hold = 0;   // cycles the receiver still holds off
    bit          jitter = 1'b1;    // random idling on both sides
    logic [19:0] page_pool [24];

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        errors++;
        $display("mismatch: %s got %h want %h", what, got, want);
    endtask

    function automatic int lookup_page(input logic [19:0] pn);
        for (int i = 0; i < NSLT; i++)
            if (pg_live[i] && pg_tag[i] == pn)
                return i;
        return -1;
    endfunction

    function automatic int free_slots();
        int c;
        c = 0;
        for (int i = 0; i < NSLT; i++)
            if (!pg_live[i])
                c++;
        return c;
    endfunction

    function automatic int alloc_page(input logic [19:0] pn, input logic [3:0] perm);
        for (int i = 0; i < NSLT; i++)
            if (!pg_live[i]) begin
                pg_live[i] = 1'b1;
                pg_tag[i] = pn;
                pg_perm[i] = perm;
                for (int b = 0; b < PG; b++)
                    pg_mem[i*PG + b] = 8'h00;
                return i;
            end
        return -1;
    endfunction

    function automatic pmp_result_t apply_access(input logic [2:0] op, input logic [31:0] addr,
                                                 input logic [3:0] nb, input logic [63:0] wd);
        pmp_result_t r;
        logic [3:0]  need;
        bit          store;
        int          n, off, len0, np, pk, boff, missing;
        logic [31:0] a1;
        logic [19:0] pn [2];
        int          sl [2];
        r = '0;
        case (op[1:0])
            2'd0: need = 4'b0001;
            2'd1: need = 4'b0100;
            2'd2: need = 4'b0010;
            default: need = 4'b1000;
        endcase
        store = (op == OP_WRITE || op == OP_INIT);
        n = (nb > 8) ? 8 : int'(nb);
        if (n == 0)
            return r;
        off = int'(addr[11:0]);
        len0 = (PG - off > n) ? n : PG - off;
        np = (n > len0) ? 2 : 1;
        a1 = addr + 32'(len0);
        pn[0] = addr[31:12];
        pn[1] = a1[31:12];
        for (int k = 0; k < np; k++)
            sl[k] = lookup_page(pn[k]);
        if (safe_q) begin
            for (int k = 0; k < np; k++) begin
                if (sl[k] < 0) begin
                    r.status = ST_MISSING;
                    return r;
                end
                if ((pg_perm[sl[k]] & need) != need) begin
                    r.status = ST_DENIED;
                    return r;
                end
            end
        end else if (store) begin
            missing = 0;
            for (int k = 0; k < np; k++)
                if (sl[k] < 0)
                    missing++;
            if (missing > free_slots()) begin
                r.status = ST_FULL;
                return r;
            end
            for (int k = 0; k < np; k++)
                if (sl[k] < 0)
                    sl[k] = alloc_page(pn[k], 4'hF);
        end
        for (int i = 0; i < n; i++) begin
            pk = (i < len0) ? 0 : 1;
            boff = (pk == 0) ? off + i : i - len0;
            if (sl[pk] >= 0) begin
                if (store)
                    pg_mem[sl[pk]*PG + boff] = wd[8*i +: 8];
                else
                    r.read_data[8*i +: 8] = pg_mem[sl[pk]*PG + boff];
            end
        end
        return r;
    endfunction

    function automatic pmp_result_t apply_range(input logic [2:0] op, input logic [31:0] addr,
                                                input logic [23:0] len, input logic [3:0] perm);
        pmp_result_t r;
        logic [31:0] lastb;
        logic [19:0] pn, span;
        int          s, cnt;
        r = '0;
        if (len == 0)
            return r;
        lastb = addr + {8'h0, len} - 32'd1;
        span = lastb[31:12] - addr[31:12];
        cnt = int'(span) + 1;
        pn = addr[31:12];
        for (int c = 0; c < cnt; c++) begin
            s = lookup_page(pn);
            if (op == OP_MAP) begin
                if (s < 0) begin
                    s = alloc_page(pn, perm);
                    if (s < 0) begin
                        r.status = ST_FULL;
                        return r;
                    end
                end
                pg_perm[s] = pg_perm[s] | perm;
            end else if (op == OP_UNMAP) begin
                if (s >= 0)
                    pg_live[s] = 1'b0;
            end else if (s >= 0) begin
                pg_perm[s] = perm;
            end
            pn = pn + 20'd1;
        end
        return r;
    endfunction

    function automatic pmp_result_t predict_item(input logic [135:0] d);
        logic [2:0] op;
        op = d[2:0];
        if (op <= OP_INIT)
            return apply_access(op, d[34:3], d[38:35], d[102:39]);
        if (op <= OP_PROTECT)
            return apply_range(op, d[34:3], d[130:107], d[106:103]);
        return '0;
    endfunction

    // One input transfer; prediction is made at the accepting edge.
    task automatic send_item(input logic [2:0] op, input logic [31:0] addr,
                             input logic [3:0] nb, input logic [63:0] wd,
                             input logic [3:0] perm, input logic [23:0] len);
        logic [135:0] d;
        d = {5'd0, len, perm, wd, nb, addr, op};
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        exp_results.push_back(predict_item(d));
        if (jitter && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (exp_results.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // Register write only with the pipe empty.
    task automatic set_safe(input logic v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        safe_q = v;
        @(posedge aclk);
    endtask

    // Result receiver with random stalls and an optional long hold-off.
    initial begin
        forever begin
            @(posedge aclk);
            if (stall_hold > 0) begin
                m_tready <= 1'b0;
                stall_hold--;
            end else begin
                m_tready <= !(jitter && $urandom_range(99) < 6);
            end
        end
    end

    // Result checker.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (exp_results.size() == 0) begin
                report("unexpected transfer", m_tdata[63:0], 64'h0);
            end else begin
                if (m_tdata[63:0] !== exp_results[0].read_data)
                    report("read_data", m_tdata[63:0], exp_results[0].read_data);
                if (m_tdata[65:64] !== exp_results[0].status)
                    report("status", 64'(m_tdata[65:64]), 64'(exp_results[0].status));
                void'(exp_results.pop_front());
            end
        end
    end

    function automatic logic [31:0] pick_addr();
        logic [11:0] off;
        case ($urandom_range(3))
            0: off = 12'(4088 + $urandom_range(7));
            1: off = 12'($urandom_range(15));
            default: off = 12'($urandom);
        endcase
        return {page_pool[$urandom_range(23)], off};
    endfunction

    function automatic logic [23:0] pick_len();
        if ($urandom_range(99) < 3)
            return 24'($urandom_range(8192));
        return 24'($urandom_range(12000, 1));
    endfunction

    // Mixed traffic over a small pool of pages so that hits are common.
    task automatic run_random(input int count);
        int w;
        logic [2:0] op;
        logic [23:0] len;
        for (int i = 0; i < count; i++) begin
            w = $urandom_range(99);
            if (w < 8) begin
                // noise: any field value, but a cheap range for a map
                op = 3'($urandom);
                len = (op == OP_MAP) ? 24'($urandom_range(4096)) : 24'($urandom);
                send_item(op, $urandom, 4'($urandom), {$urandom, $urandom},
                          4'($urandom), len);
            end else begin
                if (w < 28)      op = OP_READ;
                else if (w < 36) op = OP_EXEC;
                else if (w < 56) op = OP_WRITE;
                else if (w < 64) op = OP_INIT;
                else if (w < 78) op = OP_MAP;
                else if (w < 83) op = OP_UNMAP;
                else if (w < 97) op = OP_PROTECT;
                else             op = 3'd7;
                len = pick_len();
                if (op == OP_UNMAP || op == OP_PROTECT)
                    if ($urandom_range(99) < 2)
                        len = 24'($urandom) | 24'h800000;
                send_item(op, pick_addr(), 4'($urandom_range(8, 1)), {$urandom, $urandom},
                          4'($urandom), len);
            end
        end
    endtask

    task automatic test_directed();
        send_item(OP_READ,    32'h0000_5000, 4'd4, '0, 4'h0, 24'd0);        // missing page
        send_item(OP_MAP,     32'h0000_5000, 4'd0, '0, 4'h1, 24'd1);
        send_item(OP_READ,    32'h0000_5ffc, 4'd4, '0, 4'h0, 24'd0);        // zeroed page
        send_item(OP_WRITE,   32'h0000_5010, 4'd8, '1, 4'h0, 24'd0);        // denied
        send_item(OP_PROTECT, 32'h0000_5fff, 4'd0, '0, 4'hF, 24'd1);
        send_item(OP_WRITE,   32'h0000_5ffc, 4'd8, 64'h0123_4567_89ab_cdef, 4'h0, 24'd0);
        send_item(OP_MAP,     32'h0000_6000, 4'd0, '0, 4'h7, 24'd4096);
        send_item(OP_WRITE,   32'h0000_5ffc, 4'd8, 64'h0123_4567_89ab_cdef, 4'h0, 24'd0);
        send_item(OP_READ,    32'h0000_5ffa, 4'd8, '0, 4'h0, 24'd0);
        send_item(OP_EXEC,    32'h0000_6000, 4'd8, '0, 4'h0, 24'd0);
        send_item(OP_INIT,    32'h0000_6000, 4'd2, '1, 4'h0, 24'd0);        // no init bit
        send_item(OP_INIT,    32'h0000_5000, 4'd8, '1, 4'h0, 24'd0);
        send_item(OP_READ,    32'h0000_5000, 4'd0, '0, 4'h0, 24'd0);        // zero length
        send_item(OP_READ,    32'h0000_5000, 4'd15, '0, 4'h0, 24'd0);       // saturated length
        send_item(3'd7,       32'hffff_ffff, 4'd15, '1, 4'hF, 24'hffffff);  // unused code
        send_item(OP_MAP,     32'h0000_9000, 4'd0, '0, 4'hF, 24'd0);        // empty range
        send_item(OP_MAP,     32'hffff_f800, 4'd0, '0, 4'hF, 24'd4096);     // wraps to page 0
        send_item(OP_WRITE,   32'hffff_fffc, 4'd8, 64'hfeed_face_cafe_beef, 4'h0, 24'd0);
        send_item(OP_READ,    32'hffff_fffd, 4'd8, '0, 4'h0, 24'd0);
        send_item(OP_UNMAP,   32'h0000_5fff, 4'd0, '0, 4'h0, 24'd2);        // unaligned: 5 and 6
        send_item(OP_READ,    32'h0000_6000, 4'd1, '0, 4'h0, 24'd0);
        send_item(OP_MAP,     32'h0010_0000, 4'd0, '0, 4'h3, 24'hffffff);   // runs out of slots
        send_item(OP_PROTECT, 32'h0010_0000, 4'd0, '0, 4'h0, 24'hffffff);
        send_item(OP_UNMAP,   32'h0000_0000, 4'd0, '0, 4'h0, 24'hffffff);
        send_item(OP_UNMAP,   32'h0010_0000, 4'd0, '0, 4'h0, 24'hffffff);
    endtask

    task automatic test_unsafe_mode();
        set_safe(1'b0);
        send_item(OP_READ,  32'h0000_3ffe, 4'd8, '0, 4'h0, 24'd0);          // missing -> zeros
        send_item(OP_WRITE, 32'h0000_3ffe, 4'd8, 64'h1122_3344_5566_7788, 4'h0, 24'd0);
        send_item(OP_READ,  32'h0000_3ffc, 4'd8, '0, 4'h0, 24'd0);
        send_item(OP_MAP,   32'h0020_0000, 4'd0, '0, 4'h0, 24'hffffff);     // fill the table
        send_item(OP_INIT,  32'h0000_7ffc, 4'd8, '1, 4'h0, 24'd0);          // no room
        send_item(OP_UNMAP, 32'h0020_0000, 4'd0, '0, 4'h0, 24'd4096);
        send_item(OP_INIT,  32'h0000_7ffc, 4'd8, '1, 4'h0, 24'd0);          // one slot, needs two
        send_item(OP_WRITE, 32'h0000_7ff0, 4'd8, '1, 4'h0, 24'd0);
        run_random(250);
        send_item(OP_UNMAP, 32'h0000_0000, 4'd0, '0, 4'h0, 24'hffffff);
    endtask

    task automatic test_backpressure();
        drain();
        stall_hold = 400;
        jitter = 1'b0;
        run_random(60);
        jitter = 1'b1;
    endtask

    initial begin
        page_pool[0] = 20'h00000;
        page_pool[1] = 20'hfffff;
        page_pool[2] = 20'h80000;
        page_pool[3] = 20'h00001;
        for (int i = 4; i < 24; i++)
            page_pool[i] = (i < 14) ? 20'(i) : 20'($urandom);
        for (int i = 0; i < NSLT; i++) begin
            pg_live[i] = 1'b0;
            pg_tag[i] = '0;
            pg_perm[i] = '0;
        end
        safe_q = 1'b1;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        run_random(450);
        test_unsafe_mode();
        set_safe(1'b1);
        test_backpressure();
        jitter = 1'b0;                      // a stretch with no idling
        run_random(150);
        jitter = 1'b1;
        set_safe(1'b0);
        run_random(100);
        set_safe(1'b1);
        run_random(150);

        drain();
        repeat (50) @(posedge aclk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #2_000_000_000;
        $display("TEST FAILED");
        $finish;
    end
endmodule

### files.f
+incdir+rtl/core
rtl/core/pmp_pkg.sv
rtl/core/pmp_ram.sv
rtl/core/pmp_front.sv
rtl/core/pmp_back.sv
rtl/core/paged_memory_with_permissions.sv
rtl/core/pmp_checker.sv
test/tb_paged_memory_with_permissions.sv
